// ===== rtl/palette_gradient_lookup_assert.svh =====
// Assertion macros shared by the palette lookup checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PALETTE_GRADIENT_LOOKUP_ASSERT_SVH
`define PALETTE_GRADIENT_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PGL_ASSERT_SAME(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PGL_ASSERT_NEXT(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

// ===== rtl/pgl_pkg.sv =====
// Types and codes shared by the palette gradient lookup block.
// Depends on nothing; imported by the interfaces, the datapath and the checker.
package pgl_pkg;

    // What one request beat asks for.
    typedef enum logic [0:0] {
        CMD_LOOKUP = 1'b0,
        CMD_WRITE  = 1'b1
    } pgl_cmd_t;

    // One palette colour, also the payload of one result beat.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pgl_rgb_t;

    // Width of the colour index and of one channel.
    localparam int unsigned IndexW   = 17;
    localparam int unsigned ChannelW = 8;
    localparam int unsigned SegRows  = 256;

endpackage

// ===== rtl/pgl_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on pgl_pkg for the command type.
interface pgl_req_if;
    import pgl_pkg::*;

    logic               valid;
    logic               ready;
    pgl_cmd_t           command;
    logic signed [16:0] colour_index;
    logic [7:0]         entry_slot;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;

    modport source (
        output valid, command, colour_index, entry_slot, entry_red, entry_green, entry_blue,
        input  ready
    );

    modport sink (
        input  valid, command, colour_index, entry_slot, entry_red, entry_green, entry_blue,
        output ready
    );
endinterface

interface pgl_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (
        output valid, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue,
        output ready
    );
endinterface

// ===== rtl/pgl_blend.sv =====
// Linear blend of one colour channel between two neighbouring palette entries.
// Depends on pgl_pkg for the channel width.
module pgl_blend (
    input  logic [7:0] lo,
    input  logic [7:0] hi,
    input  logic [7:0] frac,
    output logic [7:0] value
);
    import pgl_pkg::*;

    logic [8:0]  lo_weight;
    logic [16:0] lo_part;
    logic [16:0] hi_part;
    logic [16:0] sum;

    // The weights add up to 256, so the sum never exceeds 255 * 256.
    always_comb
    begin
        lo_weight = 9'd256 - {1'b0, frac};
        lo_part   = 17'(lo) * 17'(lo_weight);
        hi_part   = 17'(hi) * 17'(frac);
        sum       = lo_part + hi_part;
        value     = sum[2*ChannelW-1:ChannelW];
    end
endmodule

// ===== rtl/palette_gradient_lookup.sv =====
// Palette gradient lookup: a palette memory with two read ports and a blend stage.
// A lookup passes through the registered palette reads and then the output register before its result shows.
// Throughput: one beat per clock while the result side takes beats; the two palette reads of a lookup share one cycle.
// Writes take effect at their accept edge and produce no result beat.
// Reset clears the pipeline valid flags only; palette contents are undefined until written.
// Depends on pgl_pkg, pgl_if and pgl_blend.
module palette_gradient_lookup #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    pgl_req_if.sink          req,
    pgl_rsp_if.source        rsp
);
    import pgl_pkg::*;

    localparam int unsigned AddrW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int unsigned SegCount = PALETTE_ENTRIES - 1;

    // Palette memory, one RGB entry per slot.
    pgl_rgb_t pal_mem [PALETTE_ENTRIES];

    // Segment number of each high index byte, reduced modulo the segment count.
    logic [AddrW-1:0] seg_tab [SegRows];

    for (genvar g = 0; g < SegRows; g++)
    begin : g_seg
        localparam int unsigned SegRow = g % SegCount;
        assign seg_tab[g] = AddrW'(SegRow);
    end

    logic             req_fire;
    logic             lookup_fire;
    logic             write_fire;
    logic             slot_in_range;
    logic             out_free;
    logic             s1_free;
    logic [AddrW-1:0] rd_lo_addr;
    logic [AddrW-1:0] rd_hi_addr;
    logic [7:0]       frac;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    pgl_rgb_t         lo_reg;
    pgl_rgb_t         hi_reg;
    logic [7:0]       frac_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    pgl_rgb_t         out_reg;
    pgl_rgb_t         blend_rgb;

    // Handshake: the output register frees the blend stage, which frees the input.
    always_comb
    begin
        out_free      = !out_valid_reg || rsp.ready;
        s1_free       = !s1_valid_reg || out_free;
        req_fire      = req.valid && s1_free;
        lookup_fire   = req_fire && (req.command == CMD_LOOKUP);
        write_fire    = req_fire && (req.command == CMD_WRITE);
        slot_in_range = {1'b0, req.entry_slot} < 9'(PALETTE_ENTRIES);
    end

    assign req.ready = s1_free;

    // Read addresses: a negative index pins both reads to the last entry with no blend.
    always_comb
    begin
        if (req.colour_index[IndexW-1])
        begin
            rd_lo_addr = AddrW'(PALETTE_ENTRIES - 1);
            rd_hi_addr = AddrW'(PALETTE_ENTRIES - 1);
            frac       = '0;
        end
        else
        begin
            rd_lo_addr = seg_tab[req.colour_index[15:8]];
            rd_hi_addr = rd_lo_addr + AddrW'(1);
            frac       = req.colour_index[7:0];
        end
    end

    // Palette memory: one write port, two registered read ports, read before write.
    always_ff @(posedge clk)
    begin
        if (write_fire && slot_in_range)
        begin
            pal_mem[req.entry_slot[AddrW-1:0]] <= '{req.entry_red, req.entry_green,
                                                   req.entry_blue};
        end
        if (lookup_fire)
        begin
            lo_reg   <= pal_mem[rd_lo_addr];
            hi_reg   <= pal_mem[rd_hi_addr];
            frac_reg <= frac;
        end
    end

    // One blend unit per channel.
    pgl_blend u_blend_red (
        .lo    (lo_reg.red),
        .hi    (hi_reg.red),
        .frac  (frac_reg),
        .value (blend_rgb.red)
    );

    pgl_blend u_blend_green (
        .lo    (lo_reg.green),
        .hi    (hi_reg.green),
        .frac  (frac_reg),
        .value (blend_rgb.green)
    );

    pgl_blend u_blend_blue (
        .lo    (lo_reg.blue),
        .hi    (hi_reg.blue),
        .frac  (frac_reg),
        .value (blend_rgb.blue)
    );

    // Valid flags of the read stage and the output register.
    always_comb
    begin
        if (lookup_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register takes the blended colour whenever it moves on.
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_reg <= blend_rgb;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.red   = out_reg.red;
    assign rsp.green = out_reg.green;
    assign rsp.blue  = out_reg.blue;
endmodule

// ===== rtl/pgl_checker.sv =====
// Port-level checks of the palette gradient lookup, bound to the top level.
// Depends on pgl_pkg and palette_gradient_lookup_assert.svh.
`include "palette_gradient_lookup_assert.svh"

module pgl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input pgl_pkg::pgl_cmd_t req_command,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [7:0]        rsp_red,
    input logic [7:0]        rsp_green,
    input logic [7:0]        rsp_blue
);
    import pgl_pkg::*;

    logic lookup_beat;
    logic rsp_stall;

    assign lookup_beat = req_valid && req_ready && (req_command == CMD_LOOKUP);
    assign rsp_stall   = rsp_valid && !rsp_ready;

    // With the output side empty the block must be able to take a request beat.
    `PGL_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !rsp_valid, req_ready,
        "request side stalled while no result is pending")

    // A lookup taken with no result pending must be followed by a result beat.
    `PGL_ASSERT_NEXT(a_lookup_result, clk, rst_n, lookup_beat && !rsp_valid, ##1 rsp_valid,
        "lookup beat produced no result in time")

    // A stalled result beat holds its colour.
    `PGL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall,
        rsp_valid && $stable({rsp_red, rsp_green, rsp_blue}),
        "stalled result beat changed or vanished")
endmodule

bind palette_gradient_lookup pgl_checker u_pgl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.command),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_red     (rsp.red),
    .rsp_green   (rsp.green),
    .rsp_blue    (rsp.blue)
);

// ===== verif/palette_gradient_lookup_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for palette_gradient_lookup: palette writes and colour lookups.
// Depends on pgl_pkg, pgl_if and the block itself; predicts every result beat in-line.
module palette_gradient_lookup_tb;
    import pgl_pkg::*;

    localparam int unsigned Entries   = 256;
    localparam int unsigned LastSlot  = Entries - 1;
    localparam int unsigned SegSpan   = (Entries - 1) * 256;
    localparam int unsigned IdleLimit = 2000;
    localparam int unsigned HoldLen   = 150;
    localparam int unsigned ItemGoal  = 1250;

    // One request beat as it will be driven.
    typedef struct {
        pgl_cmd_t           command;
        logic signed [16:0] colour_index;
        logic [7:0]         entry_slot;
        logic [7:0]         entry_red;
        logic [7:0]         entry_green;
        logic [7:0]         entry_blue;
    } palette_req_t;

    logic clk = 1'b0;
    logic rst_n;

    pgl_req_if req ();
    pgl_rsp_if rsp ();

    palette_gradient_lookup #(
        .PALETTE_ENTRIES(Entries)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    palette_req_t pending_beats[$];
    pgl_rgb_t     expected_colours[$];
    pgl_rgb_t     palette_copy[Entries];
    bit           slot_filled[Entries];
    palette_req_t next_beat;

    int  total_beats;
    int  beats_driven;
    int  mismatch_count;
    int  results_seen;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_done;
    logic req_taken;

    always #6 clk = ~clk;

    // Folds a non-negative gradient position into the span of the palette segments.
    function automatic logic [15:0] fold_index(input logic signed [16:0] idx);
        logic [15:0] pos;
        pos = idx[15:0];
        if (pos >= 16'(SegSpan))
            pos = pos - 16'(SegSpan);
        return pos;
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [7:0] frac);
        int acc;
        acc = int'(lo) * (256 - int'(frac)) + int'(hi) * int'(frac);
        return 8'(acc >> 8);
    endfunction

    // Expected colour for a lookup against the current palette contents.
    function automatic pgl_rgb_t interpolate_colour(input logic signed [16:0] idx);
        logic [15:0] pos;
        pgl_rgb_t    lo;
        pgl_rgb_t    hi;
        pgl_rgb_t    mix;
        if (idx[16])
            return palette_copy[LastSlot];
        pos       = fold_index(idx);
        lo        = palette_copy[pos[15:8]];
        hi        = palette_copy[pos[15:8] + 8'd1];
        mix.red   = mix_channel(lo.red, hi.red, pos[7:0]);
        mix.green = mix_channel(lo.green, hi.green, pos[7:0]);
        mix.blue  = mix_channel(lo.blue, hi.blue, pos[7:0]);
        return mix;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_channel(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic queue_write(input int slot, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        palette_req_t beat;
        beat.command      = CMD_WRITE;
        beat.colour_index = 17'($urandom);
        beat.entry_slot   = 8'(slot);
        beat.entry_red    = r;
        beat.entry_green  = g;
        beat.entry_blue   = b;
        pending_beats.push_back(beat);
        slot_filled[slot] = 1'b1;
    endtask

    // Unwritten entries must never be read, so fill them with random colours first.
    task automatic ensure_slot(input int slot);
        if (!slot_filled[slot])
            queue_write(slot, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic queue_lookup(input logic signed [16:0] idx);
        palette_req_t beat;
        logic [15:0]  pos;
        if (idx[16])
            ensure_slot(LastSlot);
        else
        begin
            pos = fold_index(idx);
            ensure_slot(int'(pos[15:8]));
            ensure_slot(int'(pos[15:8]) + 1);
        end
        beat.command      = CMD_LOOKUP;
        beat.colour_index = idx;
        beat.entry_slot   = 8'($urandom);
        beat.entry_red    = 8'($urandom);
        beat.entry_green  = 8'($urandom);
        beat.entry_blue   = 8'($urandom);
        pending_beats.push_back(beat);
    endtask

    // Quarter of the run: plain, sender idling, receiver stalling, both.
    function automatic int phase_of(input int n);
        return (n * 4) / total_beats;
    endfunction

    function automatic int sender_idle_pct(input int n);
        case (phase_of(n))
            1:       return 71;
            3:       return 36;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input int n);
        case (phase_of(n))
            2:       return 71;
            3:       return 36;
            default: return 0;
        endcase
    endfunction

    // Driver: a new request beat is offered only once the previous one has gone.
    always @(negedge clk)
    begin
        if (rst_n && (!req.valid || req_taken))
        begin
            if (pending_beats.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(beats_driven))
            begin
                next_beat        = pending_beats.pop_front();
                req.command      <= next_beat.command;
                req.colour_index <= next_beat.colour_index;
                req.entry_slot   <= next_beat.entry_slot;
                req.entry_red    <= next_beat.entry_red;
                req.entry_green  <= next_beat.entry_green;
                req.entry_blue   <= next_beat.entry_blue;
                req.valid        <= 1'b1;
                beats_driven++;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Result side ready, with one long hold early on so that the pipeline backs up.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (!hold_done && beats_driven >= total_beats / 8)
        begin
            hold_done <= 1'b1;
            hold_left <= HoldLen;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= receiver_stall_pct(beats_driven));
    end

    // Monitor: checks result beats, updates the palette copy and predicts on request beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req.valid && req.ready;

            if (rsp.valid && rsp.ready)
            begin
                if (expected_colours.size() == 0)
                    report_mismatch("result beat with no lookup outstanding");
                else
                begin
                    check_channel("red", rsp.red, expected_colours[0].red);
                    check_channel("green", rsp.green, expected_colours[0].green);
                    check_channel("blue", rsp.blue, expected_colours[0].blue);
                    void'(expected_colours.pop_front());
                end
                results_seen++;
            end

            if (req.valid && req.ready)
            begin
                if (req.command == CMD_WRITE)
                    palette_copy[req.entry_slot] = {req.entry_red, req.entry_green,
                                                    req.entry_blue};
                else
                    expected_colours.push_back(interpolate_colour(req.colour_index));
            end

            // Watchdog on cycles where neither channel moves a beat.
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IdleLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int          sel;
        logic [15:0] pos;

        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.command      = CMD_LOOKUP;
        req.colour_index = '0;
        req.entry_slot   = '0;
        req.entry_red    = '0;
        req.entry_green  = '0;
        req.entry_blue   = '0;
        rsp.ready        = 1'b0;
        req_taken        = 1'b0;
        beats_driven     = 0;
        mismatch_count   = 0;
        results_seen     = 0;
        quiet_cycles     = 0;
        hold_left        = 0;
        hold_done        = 1'b0;

        // Directed part: channel extremes, both segment ends, the wrap and negative indexes.
        queue_write(0, 8'd255, 8'd255, 8'd255);
        queue_write(1, 8'd0, 8'd0, 8'd0);
        queue_write(254, 8'd0, 8'd255, 8'd1);
        queue_write(255, 8'd255, 8'd0, 8'd128);
        queue_write(128, 8'd1, 8'd128, 8'd254);
        queue_lookup(17'sd0);
        queue_lookup(17'sd255);
        queue_lookup(17'sd256);
        queue_lookup(17'sd32896);
        queue_lookup(17'sd65279);
        queue_lookup(17'sd65280);
        queue_lookup(17'sd65535);
        queue_lookup(-17'sd1);
        queue_lookup(-17'sd65536);
        // Overwriting the last entry must show up on the next negative lookup.
        queue_write(255, 8'd7, 8'd200, 8'd0);
        queue_lookup(-17'sd12345);
        queue_lookup(17'sd65279);

        // Random part: mostly lookups over the whole index range, with writes mixed in.
        while (pending_beats.size() < ItemGoal)
        begin
            sel = $urandom_range(99);
            if (sel < 25)
                queue_write($urandom_range(LastSlot), 8'($urandom), 8'($urandom),
                            8'($urandom));
            else
            begin
                sel = $urandom_range(99);
                if (sel < 45)
                    queue_lookup(17'($urandom));
                else if (sel < 60)
                    queue_lookup({1'b1, 16'($urandom)});
                else if (sel < 75)
                    queue_lookup(17'(SegSpan + $urandom_range(255)));
                else
                begin
                    pos[15:8] = 8'($urandom_range(LastSlot - 1));
                    pos[7:0]  = $urandom_range(1) ? 8'hFF : 8'h00;
                    queue_lookup({1'b0, pos});
                end
            end
        end
        total_beats = pending_beats.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all beats sent and every lookup answered, then a short wait for stray beats.
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || req.valid || expected_colours.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
